FILE: rtl/ogvd_pkg.sv
// ----------------------------------------------------------------------------
// ogvd_pkg
// Shared types, codes and constants of the occupancy grid vote downsampler.
// ----------------------------------------------------------------------------
package ogvd_pkg;

    // default capacity
    localparam int MAX_COARSE_SIDE_DEF = 256;
    localparam int MAX_BLOCK_DIM_DEF   = 16;
    localparam int MAX_FINE_SIDE_DEF   = 4096;

    // field widths
    localparam int CELL_W      = 8;
    localparam int FINE_SIZE_W = 13;
    localparam int OFFSET_W    = 14;
    localparam int COORD_W     = 8;
    localparam int STATE_W     = 2;
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int BD_REG_W    = 5;
    localparam int COUNT_W     = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    localparam logic signed [CELL_W-1:0] CELL_OCCUPIED = 8'sd100;
    localparam logic signed [CELL_W-1:0] CELL_FREE     = 8'sd0;

    localparam logic FUNC_HEADER = 1'b0;
    localparam logic FUNC_CELL   = 1'b1;

    // register reset values
    localparam logic [CFG_W-1:0]    CW_RESET   = 9'd256;
    localparam logic [CFG_W-1:0]    CH_RESET   = 9'd256;
    localparam logic [BD_REG_W-1:0] BD_RESET   = 5'd1;
    localparam logic [CFG_W-1:0]    OBS_RESET  = 9'd3;
    localparam logic [CFG_W-1:0]    FREE_RESET = 9'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COARSE_WIDTH       = 3'd0,
        REG_COARSE_HEIGHT      = 3'd1,
        REG_BLOCK_DIM          = 3'd2,
        REG_OBSTACLE_THRESHOLD = 3'd3,
        REG_FREE_THRESHOLD     = 3'd4
    } t_cfg_reg;

    typedef enum logic [STATE_W-1:0] {
        ST_UNKNOWN  = 2'd0,
        ST_FREE     = 2'd1,
        ST_OCCUPIED = 2'd2
    } t_map_state;

    // raster position of a fine cell relative to the fine map borders
    typedef struct packed {
        logic col_first;
        logic col_last;
        logic row_first;
        logic row_last;
    } t_pos_flags;

    // vote carried by one fine cell
    typedef struct packed {
        logic occ;
        logic free;
    } t_vote;

endpackage

FILE: rtl/ogvd_if.sv
// ----------------------------------------------------------------------------
// ogvd channel interfaces
// Request, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ogvd_in_if
    import ogvd_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic signed [CELL_W-1:0]      cell_occupancy;
    logic [FINE_SIZE_W-1:0]        fine_width;
    logic [FINE_SIZE_W-1:0]        fine_height;
    logic signed [OFFSET_W-1:0]    origin_offset_x;
    logic signed [OFFSET_W-1:0]    origin_offset_y;

    modport source (output valid, func, cell_occupancy, fine_width, fine_height,
                    origin_offset_x, origin_offset_y, input ready);
    modport sink   (input valid, func, cell_occupancy, fine_width, fine_height,
                    origin_offset_x, origin_offset_y, output ready);
endinterface

interface ogvd_out_if
    import ogvd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] coarse_x;
    logic [COORD_W-1:0] coarse_y;
    logic [STATE_W-1:0] coarse_state;
    logic               changed;

    modport source (output valid, coarse_x, coarse_y, coarse_state, changed, input ready);
    modport sink   (input valid, coarse_x, coarse_y, coarse_state, changed, output ready);
endinterface

interface ogvd_cfg_if
    import ogvd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/occupancy_grid_vote_downsampler_core.sv
// ----------------------------------------------------------------------------
// occupancy_grid_vote_downsampler_core
// Folds a streamed fine occupancy map into a stored coarse map by voting.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries requests: a header (func 0) with fine map size and origin
//   offset, then the fine cells (func 1) in raster order. o_out carries one
//   result per coarse cell whose last covered fine cell arrived: its column,
//   row, new stored state and whether it changed. i_cfg writes the five
//   registers by index; it is always ready and is to be used only while
//   idle, which the block does not enforce.
// Throughput: one request per cycle while no stall or clearing pass holds
//   i_in. Per-column vote counters live in one RAM and the coarse map in
//   another, each read one stage ahead and written back one stage later,
//   with a forwarding register for the last write.
// Reset: i_rst_n clears the control state and starts a pass that writes
//   unknown into every one of the 2^(2*ceil(log2(MAX_COARSE_SIDE))) coarse
//   map entries (65536 by default); i_in is not ready meanwhile.
// Stall: while the output register is valid and o_out.ready is low, it holds,
//   the whole pipeline holds with it and i_in.ready is low.
// ----------------------------------------------------------------------------
module occupancy_grid_vote_downsampler_core
    import ogvd_pkg::*;
#(
    parameter int MAX_COARSE_SIDE = MAX_COARSE_SIDE_DEF,
    parameter int MAX_BLOCK_DIM   = MAX_BLOCK_DIM_DEF,
    parameter int MAX_FINE_SIDE   = MAX_FINE_SIDE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ogvd_in_if.sink     i_in,
    ogvd_cfg_if.sink    i_cfg,
    ogvd_out_if.source  o_out
);

    localparam int CXW  = $clog2(MAX_COARSE_SIDE);
    localparam int CSW  = $clog2(MAX_COARSE_SIDE+1);
    localparam int BDW  = $clog2(MAX_BLOCK_DIM+1);
    localparam int FW   = $clog2(MAX_FINE_SIDE+1);
    localparam int CLW  = $clog2(MAX_FINE_SIDE);
    localparam int UW   = $clog2(MAX_COARSE_SIDE*MAX_BLOCK_DIM);
    localparam int DW   = ((FW > OFFSET_W) ? FW : OFFSET_W) + 1;
    localparam int LW   = CSW + BDW;
    localparam int MAPW = 2*CXW;
    localparam int CNTW = 2*COUNT_W;

    // registers
    logic [CFG_W-1:0]    r_coarse_width, r_coarse_height, r_obs_thr, r_free_thr;
    logic [BD_REG_W-1:0] r_block_dim;

    // raster position and header
    logic [CLW-1:0]             r_col;
    logic [FW-1:0]              r_row, r_hdr_w, r_hdr_h;
    logic signed [OFFSET_W-1:0] r_ox, r_oy;

    // clearing pass
    logic            r_clr_busy;
    logic [MAPW-1:0] r_clr_addr;

    // decision stage
    logic           r5_valid, r5_first, r5_last;
    logic [CXW-1:0] r5_cx, r5_cy;
    t_vote          r5_vote;

    // forwarding of the last write
    logic            r_cfwd_valid, r_mfwd_valid;
    logic [CXW-1:0]  r_cfwd_addr;
    logic [CNTW-1:0] r_cfwd_data;
    logic [MAPW-1:0] r_mfwd_addr;
    logic [STATE_W-1:0] r_mfwd_data;

    // output register
    logic               r_out_valid, r_out_changed;
    logic [CXW-1:0]     r_out_cx, r_out_cy;
    logic [STATE_W-1:0] r_out_state;

    logic                adv, in_ready, accept, is_cell, in_map, cell_go, loc_in_valid;
    logic [CSW-1:0]      cw_c, ch_c;
    logic [BDW-1:0]      bd_c;
    logic [LW-1:0]       cwbd, chbd;
    logic [FW-1:0]       hw_c, hh_c;
    logic signed [DW-1:0] gx, gy;
    logic                cov_x, cov_y;
    t_pos_flags          flags;
    t_vote               vote;

    logic           l_valid, l_first, l_last;
    logic [CXW-1:0] l_cx, l_cy;
    t_vote          l_vote;

    logic [CNTW-1:0]    cnt_rdata, cnt_old, cnt_new;
    logic [COUNT_W-1:0] obs_base, free_base, obs_new, free_new;
    logic [STATE_W-1:0] map_rdata, map_old, code;
    logic               cnt_we, map_pipe_we, map_we;
    logic [MAPW-1:0]    map_waddr;
    logic [STATE_W-1:0] map_wdata;

    assign adv      = !r_out_valid || o_out.ready;
    assign in_ready = adv && !r_clr_busy;
    assign accept   = i_in.valid && in_ready;
    assign is_cell  = (i_in.func == FUNC_CELL);

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coarse_width  <= CW_RESET;
            r_coarse_height <= CH_RESET;
            r_block_dim     <= BD_RESET;
            r_obs_thr       <= OBS_RESET;
            r_free_thr      <= FREE_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_COARSE_WIDTH:       r_coarse_width  <= i_cfg.data;
                REG_COARSE_HEIGHT:      r_coarse_height <= i_cfg.data;
                REG_BLOCK_DIM:          r_block_dim     <= i_cfg.data[BD_REG_W-1:0];
                REG_OBSTACLE_THRESHOLD: r_obs_thr       <= i_cfg.data;
                REG_FREE_THRESHOLD:     r_free_thr      <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // clamp sizes to their legal ranges
    always_comb begin
        if (r_coarse_width == '0) begin
            cw_c = CSW'(1);
        end else if (32'(r_coarse_width) > 32'(MAX_COARSE_SIDE)) begin
            cw_c = CSW'(MAX_COARSE_SIDE);
        end else begin
            cw_c = CSW'(r_coarse_width);
        end
        if (r_coarse_height == '0) begin
            ch_c = CSW'(1);
        end else if (32'(r_coarse_height) > 32'(MAX_COARSE_SIDE)) begin
            ch_c = CSW'(MAX_COARSE_SIDE);
        end else begin
            ch_c = CSW'(r_coarse_height);
        end
        if (r_block_dim == '0) begin
            bd_c = BDW'(1);
        end else if (32'(r_block_dim) > 32'(MAX_BLOCK_DIM)) begin
            bd_c = BDW'(MAX_BLOCK_DIM);
        end else begin
            bd_c = BDW'(r_block_dim);
        end
        if (i_in.fine_width == '0) begin
            hw_c = FW'(1);
        end else if (32'(i_in.fine_width) > 32'(MAX_FINE_SIDE)) begin
            hw_c = FW'(MAX_FINE_SIDE);
        end else begin
            hw_c = FW'(i_in.fine_width);
        end
        if (i_in.fine_height == '0) begin
            hh_c = FW'(1);
        end else if (32'(i_in.fine_height) > 32'(MAX_FINE_SIDE)) begin
            hh_c = FW'(MAX_FINE_SIDE);
        end else begin
            hh_c = FW'(i_in.fine_height);
        end
    end

    assign cwbd = LW'(cw_c) * LW'(bd_c);
    assign chbd = LW'(ch_c) * LW'(bd_c);

    // position of the incoming cell in the coarse area
    assign gx    = DW'(signed'({1'b0, r_col})) - DW'(r_ox);
    assign gy    = DW'(signed'({1'b0, r_row})) - DW'(r_oy);
    assign cov_x = !gx[DW-1] && (32'(gx[DW-2:0]) < 32'(cwbd));
    assign cov_y = !gy[DW-1] && (32'(gy[DW-2:0]) < 32'(chbd));

    assign flags.col_first = (r_col == '0);
    assign flags.col_last  = (FW'(r_col) + FW'(1) == r_hdr_w);
    assign flags.row_first = (r_row == '0);
    assign flags.row_last  = (r_row + FW'(1) == r_hdr_h);
    assign vote.occ  = (i_in.cell_occupancy == CELL_OCCUPIED);
    assign vote.free = (i_in.cell_occupancy == CELL_FREE);

    assign in_map       = (r_row < r_hdr_h);
    assign cell_go      = accept && is_cell && in_map;
    assign loc_in_valid = cell_go && cov_x && cov_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_hdr_w <= FW'(1);
            r_hdr_h <= FW'(1);
            r_ox    <= '0;
            r_oy    <= '0;
        end else if (accept && !is_cell) begin
            r_col   <= '0;
            r_row   <= '0;
            r_hdr_w <= hw_c;
            r_hdr_h <= hh_c;
            r_ox    <= i_in.origin_offset_x;
            r_oy    <= i_in.origin_offset_y;
        end else if (cell_go) begin
            if (flags.col_last) begin
                r_col <= '0;
                r_row <= r_row + FW'(1);
            end else begin
                r_col <= r_col + CLW'(1);
            end
        end
    end

    ogvd_locate #(
        .MAX_COARSE_SIDE (MAX_COARSE_SIDE),
        .MAX_BLOCK_DIM   (MAX_BLOCK_DIM)
    ) u_locate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (loc_in_valid),
        .i_ux    (UW'(gx[DW-2:0])),
        .i_uy    (UW'(gy[DW-2:0])),
        .i_bd    (bd_c),
        .i_flags (flags),
        .i_vote  (vote),
        .o_valid (l_valid),
        .o_cx    (l_cx),
        .o_cy    (l_cy),
        .o_first (l_first),
        .o_last  (l_last),
        .o_vote  (l_vote)
    );

    // counters read as the cell enters the decision stage
    ogvd_ram #(
        .WIDTH (CNTW),
        .DEPTH (2**CXW)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r5_cx),
        .i_wdata (cnt_new),
        .i_re    (adv),
        .i_raddr (l_cx),
        .o_rdata (cnt_rdata)
    );

    ogvd_ram #(
        .WIDTH (STATE_W),
        .DEPTH (2**MAPW)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (adv),
        .i_raddr ({l_cy, l_cx}),
        .o_rdata (map_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (adv) begin
            r5_valid <= l_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_cx    <= l_cx;
            r5_cy    <= l_cy;
            r5_first <= l_first;
            r5_last  <= l_last;
            r5_vote  <= l_vote;
        end
    end

    // modify counters and decide
    always_comb begin
        cnt_old = (r_cfwd_valid && r_cfwd_addr == r5_cx) ? r_cfwd_data : cnt_rdata;
        if (r5_first) begin
            obs_base  = '0;
            free_base = '0;
        end else begin
            obs_base  = cnt_old[CNTW-1:COUNT_W];
            free_base = cnt_old[COUNT_W-1:0];
        end
        obs_new  = (r5_vote.occ && obs_base != COUNT_MAX) ? obs_base + COUNT_W'(1) : obs_base;
        free_new = (r5_vote.free && free_base != COUNT_MAX) ?
                   free_base + COUNT_W'(1) : free_base;
        cnt_new  = {obs_new, free_new};

        map_old = (r_mfwd_valid && r_mfwd_addr == {r5_cy, r5_cx}) ? r_mfwd_data : map_rdata;
        if (obs_new >= r_obs_thr) begin
            code = ST_OCCUPIED;
        end else if (free_new >= r_free_thr) begin
            code = ST_FREE;
        end else begin
            code = map_old;
        end
    end

    assign cnt_we      = adv && r5_valid;
    assign map_pipe_we = adv && r5_valid && r5_last;
    assign map_we      = r_clr_busy || map_pipe_we;
    assign map_waddr   = r_clr_busy ? r_clr_addr : {r5_cy, r5_cx};
    assign map_wdata   = r_clr_busy ? ST_UNKNOWN : code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfwd_valid <= 1'b0;
            r_mfwd_valid <= 1'b0;
        end else if (adv) begin
            r_cfwd_valid <= cnt_we;
            r_mfwd_valid <= map_pipe_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cfwd_addr <= r5_cx;
            r_cfwd_data <= cnt_new;
            r_mfwd_addr <= {r5_cy, r5_cx};
            r_mfwd_data <= code;
        end
    end

    // sweep the coarse map to unknown after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + MAPW'(1);
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r5_valid && r5_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_cx      <= r5_cx;
            r_out_cy      <= r5_cy;
            r_out_state   <= code;
            r_out_changed <= (code != map_old);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.coarse_x     = COORD_W'(r_out_cx);
    assign o_out.coarse_y     = COORD_W'(r_out_cy);
    assign o_out.coarse_state = r_out_state;
    assign o_out.changed      = r_out_changed;

    // no pipeline write may compete with the clearing pass
    a_clr_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r5_valid && !map_pipe_we)
        else $error("pipeline active during coarse map clear");

    // a map decision always comes with a counter write-back
    a_decide_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        map_pipe_we |-> cnt_we)
        else $error("map written without counter update");

    // a new result only follows a last-cell decision
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r5_valid && r5_last && adv))
        else $error("result without a decision");

endmodule

FILE: rtl/ogvd_ram.sv
// ----------------------------------------------------------------------------
// ogvd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ogvd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ogvd_locate.sv
// ----------------------------------------------------------------------------
// ogvd_locate
// Splits a coarse-area offset into coarse index and phase inside the block
// (reciprocal multiply, back multiply, one correction) over four stages.
// ----------------------------------------------------------------------------
module ogvd_locate
    import ogvd_pkg::*;
#(
    parameter int MAX_COARSE_SIDE = MAX_COARSE_SIDE_DEF,
    parameter int MAX_BLOCK_DIM   = MAX_BLOCK_DIM_DEF
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_adv,
    input  logic                                               i_valid,
    input  logic [$clog2(MAX_COARSE_SIDE*MAX_BLOCK_DIM)-1:0]   i_ux,
    input  logic [$clog2(MAX_COARSE_SIDE*MAX_BLOCK_DIM)-1:0]   i_uy,
    input  logic [$clog2(MAX_BLOCK_DIM+1)-1:0]                 i_bd,
    input  t_pos_flags                                         i_flags,
    input  t_vote                                              i_vote,
    output logic                                               o_valid,
    output logic [$clog2(MAX_COARSE_SIDE)-1:0]                 o_cx,
    output logic [$clog2(MAX_COARSE_SIDE)-1:0]                 o_cy,
    output logic                                               o_first,
    output logic                                               o_last,
    output t_vote                                              o_vote
);

    localparam int UW  = $clog2(MAX_COARSE_SIDE*MAX_BLOCK_DIM);
    localparam int BDW = $clog2(MAX_BLOCK_DIM+1);
    localparam int CXW = $clog2(MAX_COARSE_SIDE);
    localparam int MW  = 2*UW + 1;
    localparam int PW  = UW + BDW;

    // reciprocal table, floor(2^UW / d)
    logic [UW:0] recip_tab [MAX_BLOCK_DIM+1];
    for (genvar d = 0; d <= MAX_BLOCK_DIM; d++) begin : g_recip
        localparam int RV = (d == 0) ? 0 : (2**UW) / ((d == 0) ? 1 : d);
        assign recip_tab[d] = (UW+1)'(RV);
    end

    // stage a: captured request
    logic              ra_valid;
    logic [UW-1:0]     ra_ux, ra_uy;
    logic [BDW-1:0]    ra_bd;
    t_pos_flags        ra_flags;
    t_vote             ra_vote;
    // stage b: quotient estimate
    logic              rb_valid;
    logic [UW-1:0]     rb_ux, rb_uy, rb_qx, rb_qy;
    logic [BDW-1:0]    rb_bd;
    t_pos_flags        rb_flags;
    t_vote             rb_vote;
    // stage c: back product
    logic              rc_valid;
    logic [UW-1:0]     rc_ux, rc_uy, rc_qx, rc_qy;
    logic [PW-1:0]     rc_px, rc_py;
    logic [BDW-1:0]    rc_bd;
    t_pos_flags        rc_flags;
    t_vote             rc_vote;
    // stage d: result
    logic              rd_valid;
    logic [CXW-1:0]    rd_cx, rd_cy;
    logic              rd_first, rd_last;
    t_vote             rd_vote;

    logic [MW-1:0]  mx, my;
    logic [UW-1:0]  rx_raw, ry_raw, rx, ry, qx, qy, bd_u, bd_m1;

    assign mx = MW'(ra_ux) * MW'(recip_tab[ra_bd]);
    assign my = MW'(ra_uy) * MW'(recip_tab[ra_bd]);

    always_comb begin
        bd_u   = UW'(rc_bd);
        bd_m1  = bd_u - UW'(1);
        rx_raw = rc_ux - UW'(rc_px);
        ry_raw = rc_uy - UW'(rc_py);
        // estimate is exact or one short
        if (rx_raw >= bd_u) begin
            rx = rx_raw - bd_u;
            qx = rc_qx + UW'(1);
        end else begin
            rx = rx_raw;
            qx = rc_qx;
        end
        if (ry_raw >= bd_u) begin
            ry = ry_raw - bd_u;
            qy = rc_qy + UW'(1);
        end else begin
            ry = ry_raw;
            qy = rc_qy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_valid <= 1'b0;
            rb_valid <= 1'b0;
            rc_valid <= 1'b0;
            rd_valid <= 1'b0;
        end else if (i_adv) begin
            ra_valid <= i_valid;
            rb_valid <= ra_valid;
            rc_valid <= rb_valid;
            rd_valid <= rc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            ra_ux    <= i_ux;
            ra_uy    <= i_uy;
            ra_bd    <= i_bd;
            ra_flags <= i_flags;
            ra_vote  <= i_vote;

            rb_ux    <= ra_ux;
            rb_uy    <= ra_uy;
            rb_bd    <= ra_bd;
            rb_flags <= ra_flags;
            rb_vote  <= ra_vote;
            rb_qx    <= mx[2*UW-1:UW];
            rb_qy    <= my[2*UW-1:UW];

            rc_ux    <= rb_ux;
            rc_uy    <= rb_uy;
            rc_bd    <= rb_bd;
            rc_flags <= rb_flags;
            rc_vote  <= rb_vote;
            rc_qx    <= rb_qx;
            rc_qy    <= rb_qy;
            rc_px    <= PW'(rb_qx) * PW'(rb_bd);
            rc_py    <= PW'(rb_qy) * PW'(rb_bd);

            rd_cx    <= CXW'(qx);
            rd_cy    <= CXW'(qy);
            rd_first <= (rx == '0 || rc_flags.col_first) && (ry == '0 || rc_flags.row_first);
            rd_last  <= (rx == bd_m1 || rc_flags.col_last) && (ry == bd_m1 || rc_flags.row_last);
            rd_vote  <= rc_vote;
        end
    end

    assign o_valid = rd_valid;
    assign o_cx    = rd_cx;
    assign o_cy    = rd_cy;
    assign o_first = rd_first;
    assign o_last  = rd_last;
    assign o_vote  = rd_vote;

endmodule

FILE: verif/occupancy_grid_vote_downsampler_core_tb.sv
// ----------------------------------------------------------------------------
// occupancy_grid_vote_downsampler_core_tb
// Streams headers and fine cells into the downsampler, with register settings
// changed between phases, and checks every coarse cell decision against an
// in-bench vote predictor. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module occupancy_grid_vote_downsampler_core_tb;
    import ogvd_pkg::*;

    typedef struct {
        logic                       func;
        logic signed [CELL_W-1:0]   occupancy;
        logic [FINE_SIZE_W-1:0]     fw;
        logic [FINE_SIZE_W-1:0]     fh;
        logic signed [OFFSET_W-1:0] ox;
        logic signed [OFFSET_W-1:0] oy;
    } t_req;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        t_map_state         st;
        logic               changed;
    } t_decision;

    typedef struct {
        logic                       func;
        logic signed [CELL_W-1:0]   occupancy;
        logic [FINE_SIZE_W-1:0]     fw;
        logic [FINE_SIZE_W-1:0]     fh;
        logic signed [OFFSET_W-1:0] ox;
        logic signed [OFFSET_W-1:0] oy;
        bit                         has_dec;
        logic [COORD_W-1:0]         ex;
        logic [COORD_W-1:0]         ey;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;

    ogvd_in_if  in_ch ();
    ogvd_cfg_if cfg_ch ();
    ogvd_out_if out_ch ();

    occupancy_grid_vote_downsampler_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // predictor state
    t_map_state  grid_state [0:65535];
    logic [8:0]  occ_votes [0:255];
    logic [8:0]  free_votes [0:255];
    int          fine_col, fine_row, map_w, map_h, org_x, org_y;
    int          reg_cw, reg_ch, reg_bd, reg_obs, reg_free;

    t_decision   pending_decisions [$];
    int          errors = 0;
    int          n_cells = 0;
    int          n_headers = 0;
    int          n_decisions = 0;
    int          n_changed = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_req = 0;
    int          hold_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    function automatic int clamp_rng(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [8:0] sat_inc(logic [8:0] c);
        return (c >= COUNT_MAX) ? COUNT_MAX : c + 9'd1;
    endfunction

    // Apply one accepted request to the predictor; return 1 with a decision.
    function automatic bit vote_step(t_req r, output t_decision d);
        int  cw, ch, bd, gx, gy, cx, cy, addr;
        bit  first, last, hit;
        t_map_state old_st, new_st;
        hit = 0;
        if (r.func == FUNC_HEADER) begin
            map_w    = clamp_rng(int'(r.fw), MAX_FINE_SIDE_DEF);
            map_h    = clamp_rng(int'(r.fh), MAX_FINE_SIDE_DEF);
            org_x    = int'(r.ox);
            org_y    = int'(r.oy);
            fine_col = 0;
            fine_row = 0;
            return 0;
        end
        if (fine_row >= map_h) return 0;
        cw = clamp_rng(reg_cw, MAX_COARSE_SIDE_DEF);
        ch = clamp_rng(reg_ch, MAX_COARSE_SIDE_DEF);
        bd = clamp_rng(reg_bd, MAX_BLOCK_DIM_DEF);
        gx = fine_col - org_x;
        gy = fine_row - org_y;
        if (gx >= 0 && gy >= 0 && gx < cw * bd && gy < ch * bd) begin
            cx = gx / bd;
            cy = gy / bd;
            first = (gx % bd == 0 || fine_col == 0) && (gy % bd == 0 || fine_row == 0);
            last  = (gx % bd == bd - 1 || fine_col == map_w - 1) &&
                    (gy % bd == bd - 1 || fine_row == map_h - 1);
            if (first) begin
                occ_votes[cx]  = '0;
                free_votes[cx] = '0;
            end
            if (r.occupancy == CELL_OCCUPIED) occ_votes[cx] = sat_inc(occ_votes[cx]);
            else if (r.occupancy == CELL_FREE) free_votes[cx] = sat_inc(free_votes[cx]);
            if (last) begin
                addr   = cy * 256 + cx;
                old_st = grid_state[addr];
                new_st = old_st;
                if (occ_votes[cx] >= reg_obs) new_st = ST_OCCUPIED;
                else if (free_votes[cx] >= reg_free) new_st = ST_FREE;
                grid_state[addr] = new_st;
                d.x       = cx[7:0];
                d.y       = cy[7:0];
                d.st      = new_st;
                d.changed = (new_st != old_st);
                hit = 1;
            end
        end
        fine_col++;
        if (fine_col >= map_w) begin
            fine_col = 0;
            fine_row++;
        end
        return hit;
    endfunction

    // Offer one request and hold it until accepted; valid stays high on return.
    task automatic send_req(t_req r, bit typed, t_decision typed_dec, bit typed_has);
        t_decision d;
        bit        hit;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.func            <= r.func;
        in_ch.cell_occupancy  <= r.occupancy;
        in_ch.fine_width      <= r.fw;
        in_ch.fine_height     <= r.fh;
        in_ch.origin_offset_x <= r.ox;
        in_ch.origin_offset_y <= r.oy;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        hit = vote_step(r, d);
        if (typed) begin
            hit = typed_has;
            d   = typed_dec;
        end
        if (hit) pending_decisions.push_back(d);
        if (r.func == FUNC_HEADER) n_headers++;
        else n_cells++;
    endtask

    task automatic send_rand(t_req r);
        t_decision unused;
        send_req(r, 0, unused, 0);
    endtask

    // Drain results and let cells with no result leave the pipeline.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_regs(int cw, int ch, int bd, int obs, int fr);
        int vals [5];
        vals = '{cw, ch, bd, obs, fr};
        for (int i = 0; i < 5; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= t_cfg_reg'(i);
            cfg_ch.data  <= vals[i][8:0];
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
        reg_cw   = cw & 9'h1FF;
        reg_ch   = ch & 9'h1FF;
        reg_bd   = bd & 5'h1F;
        reg_obs  = obs & 9'h1FF;
        reg_free = fr & 9'h1FF;
    endtask

    function automatic logic signed [CELL_W-1:0] rand_cell();
        int p;
        p = $urandom_range(99);
        if (p < 45) return CELL_OCCUPIED;
        if (p < 80) return CELL_FREE;
        if (p < 90) return -8'sd1;
        return CELL_W'($urandom);
    endfunction

    // Result side: check accepted decisions, then pick the next ready level.
    always @(posedge i_clk) begin
        t_decision e;
        if (out_ch.valid && out_ch.ready && i_rst_n) begin
            n_decisions++;
            if (out_ch.changed) n_changed++;
            if (pending_decisions.size() == 0) begin
                errors++;
                $display("%0t: unexpected decision x=%0d y=%0d st=%0d chg=%0d", $time,
                         out_ch.coarse_x, out_ch.coarse_y, out_ch.coarse_state,
                         out_ch.changed);
            end else begin
                e = pending_decisions.pop_front();
                if (out_ch.coarse_x !== e.x || out_ch.coarse_y !== e.y ||
                    out_ch.coarse_state !== e.st || out_ch.changed !== e.changed) begin
                    errors++;
                    $display("%0t: expected x=%0d y=%0d st=%0d chg=%0d, got x=%0d y=%0d st=%0d chg=%0d",
                             $time, e.x, e.y, e.st, e.changed, out_ch.coarse_x,
                             out_ch.coarse_y, out_ch.coarse_state, out_ch.changed);
                end
            end
        end
        if (hold_req) begin
            hold_req = 0;
            hold_cnt = 300;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Reset config; every result reads as unknown and unchanged.
    t_directed_row directed [] = '{
        '{FUNC_CELL,   CELL_OCCUPIED, 0,    0,    0,     0,     1, 0,   0},
        '{FUNC_CELL,   CELL_FREE,     0,    0,    0,     0,     0, 0,   0},
        '{FUNC_HEADER, 0,             3,    2,    0,     0,     0, 0,   0},
        '{FUNC_CELL,   CELL_OCCUPIED, 0,    0,    0,     0,     1, 0,   0},
        '{FUNC_CELL,   CELL_FREE,     0,    0,    0,     0,     1, 1,   0},
        '{FUNC_CELL,   -8'sd1,        0,    0,    0,     0,     1, 2,   0},
        '{FUNC_CELL,   8'sd127,       0,    0,    0,     0,     1, 0,   1},
        '{FUNC_CELL,   -8'sd128,      0,    0,    0,     0,     1, 1,   1},
        '{FUNC_CELL,   CELL_OCCUPIED, 0,    0,    0,     0,     1, 2,   1},
        '{FUNC_CELL,   CELL_FREE,     0,    0,    0,     0,     0, 0,   0},
        '{FUNC_HEADER, 0,             0,    0,    -8192, -8192, 0, 0,   0},
        '{FUNC_CELL,   CELL_OCCUPIED, 0,    0,    0,     0,     0, 0,   0},
        '{FUNC_HEADER, 0,             8191, 8191, 8191,  8191,  0, 0,   0},
        '{FUNC_CELL,   CELL_FREE,     0,    0,    0,     0,     0, 0,   0},
        '{FUNC_HEADER, 0,             4096, 1,    -255,  0,     0, 0,   0},
        '{FUNC_CELL,   CELL_OCCUPIED, 0,    0,    0,     0,     1, 255, 0},
        '{FUNC_CELL,   CELL_FREE,     0,    0,    0,     0,     0, 0,   0},
        '{FUNC_HEADER, 0,             1,    4096, 0,     -255,  0, 0,   0},
        '{FUNC_CELL,   -8'sd1,        0,    0,    0,     0,     1, 0,   255}
    };

    initial begin
        t_req      r;
        t_decision d;
        int        cw, ch, bd, fw, fh, n, mode, phase;
        i_rst_n               = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.func            = FUNC_HEADER;
        in_ch.cell_occupancy  = '0;
        in_ch.fine_width      = '0;
        in_ch.fine_height     = '0;
        in_ch.origin_offset_x = '0;
        in_ch.origin_offset_y = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = REG_COARSE_WIDTH;
        cfg_ch.data           = '0;
        out_ch.ready          = 1'b0;
        for (int i = 0; i < 65536; i++) grid_state[i] = ST_UNKNOWN;
        for (int i = 0; i < 256; i++) begin
            occ_votes[i]  = '0;
            free_votes[i] = '0;
        end
        fine_col = 0; fine_row = 0; map_w = 1; map_h = 1; org_x = 0; org_y = 0;
        reg_cw = CW_RESET; reg_ch = CH_RESET; reg_bd = BD_RESET;
        reg_obs = OBS_RESET; reg_free = FREE_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            r = '{directed[i].func, directed[i].occupancy, directed[i].fw, directed[i].fh,
                  directed[i].ox, directed[i].oy};
            d = '{directed[i].ex, directed[i].ey, ST_UNKNOWN, 1'b0};
            send_req(r, 1, d, directed[i].has_dec);
        end
        settle();

        phase = 0;
        while (n_cells + n_headers < 1050) begin
            mode = phase % 4;
            send_idle_pct = (mode == 1) ? 57 : (mode == 3) ? 28 : 0;
            stall_pct     = (mode == 2) ? 57 : (mode == 3) ? 28 : 0;
            case (phase)
                0: write_regs(256, 256, 16, 256, 256);
                1: write_regs(0, 0, 0, 0, 0);
                2: write_regs(511, 300, 31, 511, 511);
                default: begin
                    bd = $urandom_range(1, 4);
                    write_regs($urandom_range(1, 6), $urandom_range(1, 6), bd,
                               $urandom_range(0, bd * bd + 1), $urandom_range(0, bd * bd + 1));
                end
            endcase
            if (phase == 3) hold_req = 1;
            if (phase == 0) begin
                // one full 16x16 block, all occupied, must reach threshold 256
                send_rand('{FUNC_HEADER, 0, 16, 16, 0, 0});
                repeat (256) send_rand('{FUNC_CELL, CELL_OCCUPIED, 0, 0, 0, 0});
            end
            n = 0;
            while (n < 120) begin
                if ($urandom_range(9) == 0) begin
                    send_rand('{FUNC_HEADER, 0, FINE_SIZE_W'($urandom), FINE_SIZE_W'($urandom),
                                OFFSET_W'($urandom), OFFSET_W'($urandom)});
                    fw = $urandom_range(0, 5);
                end else begin
                    cw = clamp_rng(reg_cw, 256);
                    ch = clamp_rng(reg_ch, 256);
                    bd = clamp_rng(reg_bd, 16);
                    fw = $urandom_range(1, (cw * bd + 2 > 20) ? 20 : cw * bd + 2);
                    fh = $urandom_range(1, (ch * bd + 2 > 12) ? 12 : ch * bd + 2);
                    send_rand('{FUNC_HEADER, 0, fw[12:0], fh[12:0],
                                OFFSET_W'(int'($urandom_range(0, 6)) - 3),
                                OFFSET_W'(int'($urandom_range(0, 6)) - 3)});
                    fw = fw * fh;
                    case ($urandom_range(7))
                        0: fw = $urandom_range(0, fw);
                        1: fw = fw + $urandom_range(1, 4);
                        default: ;
                    endcase
                end
                n += fw + 1;
                repeat (fw) send_rand('{FUNC_CELL, rand_cell(), FINE_SIZE_W'($urandom),
                                        FINE_SIZE_W'($urandom), OFFSET_W'($urandom),
                                        OFFSET_W'($urandom)});
            end
            settle();
            phase++;
        end

        $display("covered %0d headers and %0d fine cells over %0d register settings",
                 n_headers, n_cells, phase + 1);
        $display("checked %0d coarse decisions, %0d of them changing the map",
                 n_decisions, n_changed);
        if (errors == 0 && pending_decisions.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
